// ===== hw/rtl/i2c_slave_command_data_engine_assert.svh =====
// assertion macros for the engine rtl file
`ifndef I2C_SLAVE_COMMAND_DATA_ENGINE_ASSERT_SVH
`define I2C_SLAVE_COMMAND_DATA_ENGINE_ASSERT_SVH

// same-cycle implication
`define I2CS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cs same-cycle check failed");

// next-cycle implication
`define I2CS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cs next-cycle check failed");

`endif

// ===== hw/rtl/i2cs_pkg.sv =====
package i2cs_pkg;

    localparam int CMD_DEPTH_DEF  = 8;
    localparam int DATA_DEPTH_DEF = 32;

    localparam logic [5:0] DATA_CAP_RESET = 6'd32;

    // item kinds
    localparam logic [1:0] MODE_BUS  = 2'd0;
    localparam logic [1:0] MODE_HWR  = 2'd1;
    localparam logic [1:0] MODE_HRD  = 2'd2;

    // acknowledge actions
    localparam logic [1:0] ACK_KEEP  = 2'd0;
    localparam logic [1:0] ACK_SET   = 2'd1;
    localparam logic [1:0] ACK_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic REG_CMD_LEN  = 1'b0;
    localparam logic REG_DATA_CAP = 1'b1;

    // slave status codes
    localparam logic [7:0] ST_GC_ARB   = 8'h78;
    localparam logic [7:0] ST_GC       = 8'h70;
    localparam logic [7:0] ST_SLA_ARB  = 8'h68;
    localparam logic [7:0] ST_SLA      = 8'h60;
    localparam logic [7:0] ST_RX_SLA   = 8'h80;
    localparam logic [7:0] ST_RX_GC    = 8'h90;
    localparam logic [7:0] ST_STOP     = 8'hA0;
    localparam logic [7:0] ST_TX_ARB   = 8'hB0;
    localparam logic [7:0] ST_TX_SLA   = 8'hA8;
    localparam logic [7:0] ST_TX_ACK   = 8'hB8;
    localparam logic [7:0] ST_TX_NACK  = 8'hC0;

    typedef enum logic [1:0] {
        PH_READY,
        PH_CMD,
        PH_DATA,
        PH_TX
    } phase_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
        logic [7:0] reply_length;
        logic       buffer_select;
        logic [4:0] buffer_index;
        logic [7:0] host_byte;
    } item_t;

    typedef struct packed {
        logic [1:0] ack_action;
        logic       tx_valid;
        logic       tx_load;
        logic       stop_seen;
        logic [3:0] command_count;
        logic [5:0] data_count;
        logic       general_call;
        logic       protocol_error;
        logic       rd_cmd;
        logic       rd_data;
    } meta_t;

    typedef struct packed {
        logic cmd_we;
        logic cmd_re;
        logic data_we;
        logic data_re;
    } store_ctl_t;

endpackage

// ===== hw/rtl/i2cs_store.sv =====
module i2cs_store #(
    parameter int CMD_DEPTH  = i2cs_pkg::CMD_DEPTH_DEF,
    parameter int DATA_DEPTH = i2cs_pkg::DATA_DEPTH_DEF,
    localparam int CMD_AW    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1,
    localparam int DATA_AW   = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   en,
    input  i2cs_pkg::store_ctl_t   ctl,
    input  logic [CMD_AW-1:0]      cmd_addr,
    input  logic [DATA_AW-1:0]     data_addr,
    input  logic [7:0]             wdata,
    output logic [7:0]             cmd_rdata,
    output logic [7:0]             data_rdata
);

    logic [7:0] cmd_mem [CMD_DEPTH];
    logic [7:0] data_mem [DATA_DEPTH];
    logic [7:0] cmd_rdata_reg;
    logic [7:0] data_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && ctl.cmd_we)
        begin
            cmd_mem[cmd_addr] <= wdata;
        end
        if (en && ctl.cmd_re)
        begin
            cmd_rdata_reg <= cmd_mem[cmd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && ctl.data_we)
        begin
            data_mem[data_addr] <= wdata;
        end
        if (en && ctl.data_re)
        begin
            data_rdata_reg <= data_mem[data_addr];
        end
    end

    assign cmd_rdata  = cmd_rdata_reg;
    assign data_rdata = data_rdata_reg;

endmodule

// ===== hw/rtl/i2cs_ctrl.sv =====
module i2cs_ctrl #(
    parameter int CMD_DEPTH  = i2cs_pkg::CMD_DEPTH_DEF,
    parameter int DATA_DEPTH = i2cs_pkg::DATA_DEPTH_DEF,
    localparam int CMD_AW    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1,
    localparam int DATA_AW   = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  i2cs_pkg::item_t        item,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [5:0]             cfg_data,
    output i2cs_pkg::store_ctl_t   store_ctl,
    output logic [CMD_AW-1:0]      cmd_addr,
    output logic [DATA_AW-1:0]     data_addr,
    output logic [7:0]             store_wdata,
    output i2cs_pkg::meta_t        meta
);

    localparam int IDX_MAX = (DATA_DEPTH > 15) ? DATA_DEPTH : 15;
    localparam int IDX_W   = $clog2(IDX_MAX + 1);
    localparam int LIM_MAX = (DATA_DEPTH > 63) ? DATA_DEPTH : 63;
    localparam int LIM_W   = $clog2(LIM_MAX + 1);

    i2cs_pkg::phase_t   phase_reg;
    i2cs_pkg::phase_t   phase_next;
    logic [IDX_W-1:0]   byte_index_reg;
    logic [IDX_W-1:0]   byte_index_next;
    logic [LIM_W-1:0]   data_limit_reg;
    logic [LIM_W-1:0]   data_limit_next;
    logic               gc_reg;
    logic               gc_next;
    logic [3:0]         cmd_len_reg;

    logic               is_bus;
    logic               is_addr;
    logic               is_rx;
    logic               is_stop;
    logic               is_rd_start;
    logic               is_rd;
    logic               bad;
    logic [31:0]        idx32;
    logic [31:0]        bidx32;
    logic [31:0]        eff_limit32;
    logic [31:0]        reply_sat32;
    logic [31:0]        tx_idx32;
    logic [IDX_W-1:0]   idx_inc;
    logic [IDX_W-1:0]   tx_idx;

    assign is_bus      = (item.mode == i2cs_pkg::MODE_BUS);
    assign is_addr     = (item.bus_status == i2cs_pkg::ST_GC_ARB)
                      || (item.bus_status == i2cs_pkg::ST_GC)
                      || (item.bus_status == i2cs_pkg::ST_SLA_ARB)
                      || (item.bus_status == i2cs_pkg::ST_SLA);
    assign is_rx       = (item.bus_status == i2cs_pkg::ST_RX_SLA)
                      || (item.bus_status == i2cs_pkg::ST_RX_GC);
    assign is_stop     = (item.bus_status == i2cs_pkg::ST_STOP);
    assign is_rd_start = (item.bus_status == i2cs_pkg::ST_TX_ARB)
                      || (item.bus_status == i2cs_pkg::ST_TX_SLA);
    assign is_rd       = (item.bus_status == i2cs_pkg::ST_TX_ACK)
                      || (item.bus_status == i2cs_pkg::ST_TX_NACK);

    always_comb
    begin
        bad = 1'b0;
        if (is_bus)
        begin
            priority if (is_addr)
            begin
                bad = (phase_reg != i2cs_pkg::PH_READY);
            end
            else if (is_rx)
            begin
                bad = (phase_reg != i2cs_pkg::PH_CMD) && (phase_reg != i2cs_pkg::PH_DATA);
            end
            else if (is_stop)
            begin
                bad = 1'b0;
            end
            else if (is_rd_start)
            begin
                bad = (cmd_len_reg != 4'd0) && (phase_reg != i2cs_pkg::PH_TX);
            end
            else if (is_rd)
            begin
                bad = (phase_reg != i2cs_pkg::PH_TX);
            end
            else
            begin
                bad = 1'b1;
            end
        end
    end

    assign idx32       = 32'(byte_index_reg);
    assign bidx32      = 32'(item.buffer_index);
    assign eff_limit32 = (32'(data_limit_reg) < 32'(DATA_DEPTH)) ? 32'(data_limit_reg)
                                                                  : 32'(DATA_DEPTH);
    assign reply_sat32 = (32'(item.reply_length) > 32'(DATA_DEPTH)) ? 32'(DATA_DEPTH)
                                                                     : 32'(item.reply_length);
    assign idx_inc     = byte_index_reg + IDX_W'(1);
    assign tx_idx      = is_rd_start ? '0 : byte_index_reg;
    assign tx_idx32    = 32'(tx_idx);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_bus)
        begin
            priority if (bad)
            begin
                phase_next = i2cs_pkg::PH_READY;
            end
            else if (is_addr)
            begin
                phase_next = (cmd_len_reg != 4'd0) ? i2cs_pkg::PH_CMD : i2cs_pkg::PH_DATA;
            end
            else if (is_rx)
            begin
                if (phase_reg == i2cs_pkg::PH_CMD && 32'(idx_inc) >= 32'(cmd_len_reg))
                begin
                    phase_next = i2cs_pkg::PH_DATA;
                end
            end
            else if (is_stop)
            begin
                phase_next = (item.reply_length == 8'd0) ? i2cs_pkg::PH_READY
                                                         : i2cs_pkg::PH_TX;
            end
            else
            begin
                phase_next = (item.bus_status == i2cs_pkg::ST_TX_NACK) ? i2cs_pkg::PH_READY
                                                                       : i2cs_pkg::PH_TX;
            end
        end
    end

    // datapath and result
    always_comb
    begin
        byte_index_next = byte_index_reg;
        data_limit_next = data_limit_reg;
        gc_next         = gc_reg;
        store_ctl       = '0;
        cmd_addr        = bidx32[CMD_AW-1:0];
        data_addr       = bidx32[DATA_AW-1:0];
        store_wdata     = item.host_byte;
        meta            = '0;

        unique case (item.mode)
            i2cs_pkg::MODE_HWR:
            begin
                store_ctl.cmd_we  = !item.buffer_select && (bidx32 < 32'(CMD_DEPTH));
                store_ctl.data_we = item.buffer_select && (bidx32 < 32'(DATA_DEPTH));
            end
            i2cs_pkg::MODE_HRD:
            begin
                meta.rd_cmd       = !item.buffer_select && (bidx32 < 32'(CMD_DEPTH));
                meta.rd_data      = item.buffer_select && (bidx32 < 32'(DATA_DEPTH));
                store_ctl.cmd_re  = meta.rd_cmd;
                store_ctl.data_re = meta.rd_data;
            end
            i2cs_pkg::MODE_BUS:
            begin
                store_wdata = item.rx_byte;
                priority if (bad)
                begin
                    meta.protocol_error = 1'b1;
                    meta.ack_action     = i2cs_pkg::ACK_SET;
                end
                else if (is_addr)
                begin
                    byte_index_next = '0;
                    gc_next         = (item.bus_status == i2cs_pkg::ST_GC_ARB)
                                   || (item.bus_status == i2cs_pkg::ST_GC);
                    meta.ack_action = i2cs_pkg::ACK_SET;
                end
                else if (is_rx)
                begin
                    if (phase_reg == i2cs_pkg::PH_CMD)
                    begin
                        store_ctl.cmd_we = (idx32 < 32'(CMD_DEPTH));
                        cmd_addr         = idx32[CMD_AW-1:0];
                        byte_index_next  = (32'(idx_inc) >= 32'(cmd_len_reg)) ? '0 : idx_inc;
                        meta.ack_action  = i2cs_pkg::ACK_SET;
                    end
                    else if (idx32 < eff_limit32)
                    begin
                        store_ctl.data_we = 1'b1;
                        data_addr         = idx32[DATA_AW-1:0];
                        byte_index_next   = idx_inc;
                        meta.ack_action   = i2cs_pkg::ACK_SET;
                    end
                    else
                    begin
                        meta.ack_action = i2cs_pkg::ACK_CLEAR;
                    end
                end
                else if (is_stop)
                begin
                    meta.stop_seen = 1'b1;
                    if (phase_reg == i2cs_pkg::PH_DATA)
                    begin
                        meta.command_count = cmd_len_reg;
                        meta.data_count    = (idx32 > 32'd63) ? 6'd63 : idx32[5:0];
                    end
                    else
                    begin
                        meta.command_count = (idx32 > 32'd15) ? 4'd15 : idx32[3:0];
                    end
                    if (item.reply_length == 8'd0)
                    begin
                        meta.ack_action = i2cs_pkg::ACK_CLEAR;
                    end
                    else
                    begin
                        meta.ack_action = i2cs_pkg::ACK_SET;
                        data_limit_next = reply_sat32[LIM_W-1:0];
                        byte_index_next = '0;
                    end
                end
                else
                begin
                    meta.tx_valid   = 1'b1;
                    byte_index_next = tx_idx;
                    data_addr       = tx_idx32[DATA_AW-1:0];
                    if (tx_idx32 < eff_limit32)
                    begin
                        meta.tx_load      = 1'b1;
                        store_ctl.data_re = 1'b1;
                        byte_index_next   = tx_idx + IDX_W'(1);
                        meta.ack_action   = i2cs_pkg::ACK_SET;
                    end
                end
            end
            default:
            begin
                meta = '0;
            end
        endcase

        meta.general_call = gc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2cs_pkg::PH_READY;
            byte_index_reg <= '0;
            data_limit_reg <= LIM_W'(i2cs_pkg::DATA_CAP_RESET);
            gc_reg         <= 1'b0;
            cmd_len_reg    <= 4'd0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg      <= phase_next;
                byte_index_reg <= byte_index_next;
                data_limit_reg <= data_limit_next;
                gc_reg         <= gc_next;
            end
            else if (cfg_we)
            begin
                unique case (cfg_index)
                    i2cs_pkg::REG_CMD_LEN:  cmd_len_reg    <= cfg_data[3:0];
                    i2cs_pkg::REG_DATA_CAP: data_limit_reg <= LIM_W'(cfg_data);
                    default:                cmd_len_reg    <= cmd_len_reg;
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/i2c_slave_command_data_engine.sv =====
// I2C slave command/data engine. Each input beat is a bus status event or a
// host access to the command and data stores; each one yields exactly one
// result beat. A new beat is taken every clock cycle while results are taken;
// each beat passes through the input register and then the result register,
// which also captures the stores' registered read port. A result that is not
// taken holds the input register and then stalls the input. The stores need
// no clearing after reset, so the block is ready as soon as reset ends.
module i2c_slave_command_data_engine #(
    parameter int CMD_DEPTH  = i2cs_pkg::CMD_DEPTH_DEF,
    parameter int DATA_DEPTH = i2cs_pkg::DATA_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bus_status, rx_byte, reply_length, buffer_select, buffer_index, host_byte
    input  logic [39:0] s_tdata,
    // mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ack_action, tx_valid, tx_byte, command_count, data_count,
    // general_call, protocol_error, read_data
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int CMD_AW  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int DATA_AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

    logic                  in_valid_reg;
    i2cs_pkg::item_t       item_reg;
    logic                  out_valid_reg;
    i2cs_pkg::meta_t       meta_reg;
    i2cs_pkg::meta_t       meta_next;
    i2cs_pkg::store_ctl_t  store_ctl;
    logic [CMD_AW-1:0]     cmd_addr;
    logic [DATA_AW-1:0]    data_addr;
    logic [7:0]            store_wdata;
    logic [7:0]            cmd_rdata;
    logic [7:0]            data_rdata;
    logic                  fire;
    logic [7:0]            tx_byte;
    logic [7:0]            read_data;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.mode          <= s_tuser;
            item_reg.bus_status    <= s_tdata[7:0];
            item_reg.rx_byte       <= s_tdata[15:8];
            item_reg.reply_length  <= s_tdata[23:16];
            item_reg.buffer_select <= s_tdata[24];
            item_reg.buffer_index  <= s_tdata[29:25];
            item_reg.host_byte     <= s_tdata[37:30];
        end
        if (fire)
        begin
            meta_reg <= meta_next;
        end
    end

    i2cs_ctrl #(
        .CMD_DEPTH  (CMD_DEPTH),
        .DATA_DEPTH (DATA_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item_reg),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .store_ctl   (store_ctl),
        .cmd_addr    (cmd_addr),
        .data_addr   (data_addr),
        .store_wdata (store_wdata),
        .meta        (meta_next)
    );

    i2cs_store #(
        .CMD_DEPTH  (CMD_DEPTH),
        .DATA_DEPTH (DATA_DEPTH)
    ) u_store (
        .clk        (clk),
        .en         (fire),
        .ctl        (store_ctl),
        .cmd_addr   (cmd_addr),
        .data_addr  (data_addr),
        .wdata      (store_wdata),
        .cmd_rdata  (cmd_rdata),
        .data_rdata (data_rdata)
    );

    assign tx_byte   = meta_reg.tx_load ? data_rdata : 8'd0;
    assign read_data = meta_reg.rd_cmd  ? cmd_rdata
                     : meta_reg.rd_data ? data_rdata : 8'd0;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = meta_reg.stop_seen;
    assign m_tdata  = {1'b0,
                       read_data,
                       meta_reg.protocol_error,
                       meta_reg.general_call,
                       meta_reg.data_count,
                       meta_reg.command_count,
                       tx_byte,
                       meta_reg.tx_valid,
                       meta_reg.ack_action};

`include "i2c_slave_command_data_engine_assert.svh"

    `I2CS_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, m_tvalid)
    `I2CS_ASSERT_SAME(a_load_needs_valid, clk, rst_n, m_tvalid && meta_reg.tx_load,
        meta_reg.tx_valid && !meta_reg.rd_cmd && !meta_reg.rd_data)
    `I2CS_ASSERT_NEXT(a_host_quiet, clk, rst_n, fire && item_reg.mode != i2cs_pkg::MODE_BUS,
        !meta_reg.stop_seen && !meta_reg.protocol_error && !meta_reg.tx_valid
        && meta_reg.ack_action == i2cs_pkg::ACK_KEEP)

endmodule

// ===== tb/tb_i2c_slave_command_data_engine.sv =====
`timescale 1ns / 1ps

module tb_i2c_slave_command_data_engine;

    localparam int CMD_DEPTH    = i2cs_pkg::CMD_DEPTH_DEF;
    localparam int DATA_DEPTH   = i2cs_pkg::DATA_DEPTH_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam logic [7:0] ST_BOGUS = 8'hF8;

    typedef struct packed {
        logic [1:0] ack_action;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       stop_seen;
        logic [3:0] command_count;
        logic [5:0] data_count;
        logic       general_call;
        logic       protocol_error;
        logic [7:0] read_data;
    } engine_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [5:0]  cfg_data = '0;

    // predicted engine state
    int                 cmd_len_r = 0;
    int                 rx_limit = 32;
    i2cs_pkg::phase_t   phase_r = i2cs_pkg::PH_READY;
    int                 byte_pos = 0;
    logic               gc_r = 1'b0;
    logic [7:0]         cmd_mem [CMD_DEPTH];
    logic [7:0]         data_mem [DATA_DEPTH];
    bit                 cmd_known [CMD_DEPTH];
    bit                 data_known [DATA_DEPTH];

    engine_resp_t pending_resp [$];
    engine_resp_t got_resp;
    engine_resp_t want_resp;
    int          fail_count = 0;
    int          resp_idx = 0;
    int          beats_sent = 0;
    int          stall_cycles = 0;
    bit          idle_en = 1'b0;
    int          hold_reqs = 0;
    int          hold_served = 0;
    int          rx_wait = 0;

    i2c_slave_command_data_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int tx_window();
        return (rx_limit < DATA_DEPTH) ? rx_limit : DATA_DEPTH;
    endfunction

    function automatic engine_resp_t predict_engine(input i2cs_pkg::item_t it);
        engine_resp_t r;
        int           lim;
        bit           bad;
        r = '0;
        bad = 1'b0;
        lim = tx_window();
        if (it.mode == i2cs_pkg::MODE_HWR)
        begin
            if (!it.buffer_select)
            begin
                if (it.buffer_index < CMD_DEPTH)
                begin
                    cmd_mem[it.buffer_index] = it.host_byte;
                    cmd_known[it.buffer_index] = 1'b1;
                end
            end
            else
            begin
                data_mem[it.buffer_index] = it.host_byte;
                data_known[it.buffer_index] = 1'b1;
            end
        end
        else if (it.mode == i2cs_pkg::MODE_HRD)
        begin
            if (!it.buffer_select)
            begin
                if (it.buffer_index < CMD_DEPTH)
                    r.read_data = cmd_mem[it.buffer_index];
            end
            else
                r.read_data = data_mem[it.buffer_index];
        end
        else if (it.mode == i2cs_pkg::MODE_BUS)
        begin
            case (it.bus_status)
                i2cs_pkg::ST_GC_ARB, i2cs_pkg::ST_GC, i2cs_pkg::ST_SLA_ARB, i2cs_pkg::ST_SLA:
                begin
                    if (phase_r == i2cs_pkg::PH_READY)
                    begin
                        byte_pos = 0;
                        gc_r = (it.bus_status == i2cs_pkg::ST_GC_ARB ||
                                it.bus_status == i2cs_pkg::ST_GC);
                        phase_r = (cmd_len_r != 0) ? i2cs_pkg::PH_CMD : i2cs_pkg::PH_DATA;
                        r.ack_action = i2cs_pkg::ACK_SET;
                    end
                    else
                        bad = 1'b1;
                end
                i2cs_pkg::ST_RX_SLA, i2cs_pkg::ST_RX_GC:
                begin
                    if (phase_r == i2cs_pkg::PH_CMD)
                    begin
                        if (byte_pos < CMD_DEPTH)
                        begin
                            cmd_mem[byte_pos] = it.rx_byte;
                            cmd_known[byte_pos] = 1'b1;
                        end
                        byte_pos++;
                        if (byte_pos >= cmd_len_r)
                        begin
                            byte_pos = 0;
                            phase_r = i2cs_pkg::PH_DATA;
                        end
                        r.ack_action = i2cs_pkg::ACK_SET;
                    end
                    else if (phase_r == i2cs_pkg::PH_DATA)
                    begin
                        if (byte_pos < lim)
                        begin
                            data_mem[byte_pos] = it.rx_byte;
                            data_known[byte_pos] = 1'b1;
                            byte_pos++;
                            r.ack_action = i2cs_pkg::ACK_SET;
                        end
                        else
                            r.ack_action = i2cs_pkg::ACK_CLEAR;
                    end
                    else
                        bad = 1'b1;
                end
                i2cs_pkg::ST_STOP:
                begin
                    r.stop_seen = 1'b1;
                    if (phase_r == i2cs_pkg::PH_DATA)
                    begin
                        r.command_count = 4'(cmd_len_r);
                        r.data_count = 6'((byte_pos > 63) ? 63 : byte_pos);
                    end
                    else
                        r.command_count = 4'((byte_pos > 15) ? 15 : byte_pos);
                    if (it.reply_length == 0)
                    begin
                        r.ack_action = i2cs_pkg::ACK_CLEAR;
                        phase_r = i2cs_pkg::PH_READY;
                    end
                    else
                    begin
                        r.ack_action = i2cs_pkg::ACK_SET;
                        rx_limit = (it.reply_length > DATA_DEPTH) ? DATA_DEPTH : it.reply_length;
                        byte_pos = 0;
                        phase_r = i2cs_pkg::PH_TX;
                    end
                end
                i2cs_pkg::ST_TX_ARB, i2cs_pkg::ST_TX_SLA, i2cs_pkg::ST_TX_ACK,
                i2cs_pkg::ST_TX_NACK:
                begin
                    if (it.bus_status == i2cs_pkg::ST_TX_ARB ||
                        it.bus_status == i2cs_pkg::ST_TX_SLA)
                    begin
                        if (cmd_len_r == 0 || phase_r == i2cs_pkg::PH_TX)
                        begin
                            byte_pos = 0;
                            phase_r = i2cs_pkg::PH_TX;
                        end
                        else
                            bad = 1'b1;
                    end
                    if (!bad)
                    begin
                        if (phase_r == i2cs_pkg::PH_TX)
                        begin
                            r.tx_valid = 1'b1;
                            if (byte_pos < lim)
                            begin
                                r.tx_byte = data_mem[byte_pos];
                                byte_pos++;
                                r.ack_action = i2cs_pkg::ACK_SET;
                            end
                            if (it.bus_status == i2cs_pkg::ST_TX_NACK)
                                phase_r = i2cs_pkg::PH_READY;
                        end
                        else
                            bad = 1'b1;
                    end
                end
                default:
                    bad = 1'b1;
            endcase
            if (bad)
            begin
                r.protocol_error = 1'b1;
                r.ack_action = i2cs_pkg::ACK_SET;
                phase_r = i2cs_pkg::PH_READY;
            end
        end
        r.general_call = gc_r;
        return r;
    endfunction

    // true when the beat would read a store entry that was never written
    function automatic bit reads_blank(input i2cs_pkg::item_t it, output logic sel,
                                       output logic [4:0] idx);
        int pos;
        bit tx;
        sel = it.buffer_select;
        idx = it.buffer_index;
        if (it.mode == i2cs_pkg::MODE_HRD)
            return sel ? !data_known[idx] : (idx < CMD_DEPTH && !cmd_known[idx]);
        if (it.mode != i2cs_pkg::MODE_BUS)
            return 1'b0;
        sel = 1'b1;
        if (it.bus_status == i2cs_pkg::ST_TX_ARB || it.bus_status == i2cs_pkg::ST_TX_SLA)
        begin
            tx = (cmd_len_r == 0 || phase_r == i2cs_pkg::PH_TX);
            pos = 0;
        end
        else if (it.bus_status == i2cs_pkg::ST_TX_ACK || it.bus_status == i2cs_pkg::ST_TX_NACK)
        begin
            tx = (phase_r == i2cs_pkg::PH_TX);
            pos = byte_pos;
        end
        else
            return 1'b0;
        idx = pos[4:0];
        return tx && pos < tx_window() && !data_known[pos];
    endfunction

    function automatic string resp_text(input engine_resp_t r);
        return $sformatf("ack=%0d txv=%0b txb=%02h stop=%0b cc=%0d dc=%0d gc=%0b err=%0b rd=%02h",
                         r.ack_action, r.tx_valid, r.tx_byte, r.stop_seen, r.command_count,
                         r.data_count, r.general_call, r.protocol_error, r.read_data);
    endfunction

    function automatic logic [1:0] pick_mode();
        case ($urandom_range(0, 2))
            0: return i2cs_pkg::MODE_BUS;
            1: return i2cs_pkg::MODE_HWR;
            default: return i2cs_pkg::MODE_HRD;
        endcase
    endfunction

    function automatic logic [7:0] pick_addr();
        case ($urandom_range(0, 3))
            0: return i2cs_pkg::ST_GC_ARB;
            1: return i2cs_pkg::ST_GC;
            2: return i2cs_pkg::ST_SLA_ARB;
            default: return i2cs_pkg::ST_SLA;
        endcase
    endfunction

    function automatic logic [7:0] pick_rx();
        return $urandom_range(0, 1) ? i2cs_pkg::ST_RX_SLA : i2cs_pkg::ST_RX_GC;
    endfunction

    function automatic logic [7:0] pick_status();
        case ($urandom_range(0, 11))
            0: return i2cs_pkg::ST_GC_ARB;
            1: return i2cs_pkg::ST_GC;
            2: return i2cs_pkg::ST_SLA_ARB;
            3: return i2cs_pkg::ST_SLA;
            4: return i2cs_pkg::ST_RX_SLA;
            5: return i2cs_pkg::ST_RX_GC;
            6: return i2cs_pkg::ST_STOP;
            7: return i2cs_pkg::ST_TX_ARB;
            8: return i2cs_pkg::ST_TX_SLA;
            9: return i2cs_pkg::ST_TX_ACK;
            10: return i2cs_pkg::ST_TX_NACK;
            default: return rand_byte();
        endcase
    endfunction

    function automatic i2cs_pkg::item_t random_item();
        i2cs_pkg::item_t it;
        it.mode = pick_mode();
        it.bus_status = rand_byte();
        it.rx_byte = rand_byte();
        it.reply_length = rand_byte();
        it.buffer_select = 1'($urandom_range(0, 1));
        it.buffer_index = 5'($urandom_range(0, 31));
        it.host_byte = rand_byte();
        return it;
    endfunction

    task automatic push_beat(input i2cs_pkg::item_t it);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tdata <= {2'b00, it.host_byte, it.buffer_index, it.buffer_select,
                    it.reply_length, it.rx_byte, it.bus_status};
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        pending_resp.push_back(predict_engine(it));
        beats_sent++;
    endtask

    task automatic send_beat(input i2cs_pkg::item_t it);
        i2cs_pkg::item_t fill;
        logic            sel;
        logic [4:0]      idx;
        while (reads_blank(it, sel, idx))
        begin
            fill = random_item();
            fill.mode = i2cs_pkg::MODE_HWR;
            fill.buffer_select = sel;
            fill.buffer_index = idx;
            push_beat(fill);
        end
        push_beat(it);
    endtask

    task automatic bus_beat(input logic [7:0] st, input logic [7:0] rx,
                            input logic [7:0] reply);
        i2cs_pkg::item_t it;
        it = random_item();
        it.mode = i2cs_pkg::MODE_BUS;
        it.bus_status = st;
        it.rx_byte = rx;
        it.reply_length = reply;
        send_beat(it);
    endtask

    task automatic host_beat(input logic [1:0] md, input logic sel,
                             input logic [4:0] idx, input logic [7:0] hb);
        i2cs_pkg::item_t it;
        it = random_item();
        it.mode = md;
        it.buffer_select = sel;
        it.buffer_index = idx;
        it.host_byte = hb;
        send_beat(it);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_resp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [5:0] val);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == i2cs_pkg::REG_CMD_LEN)
            cmd_len_r = val[3:0];
        else
            rx_limit = val;
    endtask

    task automatic run_transaction();
        int         n;
        int         k;
        logic [7:0] reply;
        if (phase_r == i2cs_pkg::PH_TX)
            bus_beat(i2cs_pkg::ST_TX_NACK, rand_byte(), rand_byte());
        else if (phase_r != i2cs_pkg::PH_READY)
            bus_beat(i2cs_pkg::ST_STOP, rand_byte(), 8'd0);
        bus_beat(pick_addr(), rand_byte(), rand_byte());
        for (k = 0; k < cmd_len_r; k++)
            bus_beat(pick_rx(), rand_byte(), rand_byte());
        n = ($urandom_range(0, 3) == 0) ? tx_window() + int'($urandom_range(0, 2))
                                         : int'($urandom_range(0, 6));
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                host_beat($urandom_range(0, 1) ? i2cs_pkg::MODE_HWR : i2cs_pkg::MODE_HRD,
                          1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), rand_byte());
            bus_beat(pick_rx(), rand_byte(), rand_byte());
        end
        if ($urandom_range(0, 3) == 0)
            reply = 8'd0;
        else if ($urandom_range(0, 4) == 0)
            reply = 8'($urandom_range(33, 255));
        else
            reply = 8'($urandom_range(1, 12));
        bus_beat(i2cs_pkg::ST_STOP, rand_byte(), reply);
        if (reply != 0 && $urandom_range(0, 4) != 0)
        begin
            bus_beat($urandom_range(0, 1) ? i2cs_pkg::ST_TX_SLA : i2cs_pkg::ST_TX_ARB,
                     rand_byte(), rand_byte());
            n = ($urandom_range(0, 3) == 0) ? tx_window() + int'($urandom_range(0, 2))
                                             : int'($urandom_range(0, 4));
            for (k = 0; k < n; k++)
                bus_beat(i2cs_pkg::ST_TX_ACK, rand_byte(), rand_byte());
            if ($urandom_range(0, 3) == 0)
                bus_beat(i2cs_pkg::ST_STOP, rand_byte(), rand_byte());
            else
                bus_beat(i2cs_pkg::ST_TX_NACK, rand_byte(), rand_byte());
        end
    endtask

    task automatic test_random_traffic(input int count);
        int              start;
        i2cs_pkg::item_t it;
        start = beats_sent;
        while (beats_sent - start < count)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                it = random_item();
                if ($urandom_range(0, 1))
                    it.bus_status = pick_status();
                send_beat(it);
            end
            else
                run_transaction();
        end
    endtask

    task automatic test_host_access();
        host_beat(i2cs_pkg::MODE_HWR, 1'b0, 5'd7, 8'hFF);
        host_beat(i2cs_pkg::MODE_HWR, 1'b0, 5'd31, 8'hAA);
        host_beat(i2cs_pkg::MODE_HRD, 1'b0, 5'd31, 8'h00);
        host_beat(i2cs_pkg::MODE_HRD, 1'b0, 5'd7, 8'h00);
        host_beat(i2cs_pkg::MODE_HWR, 1'b1, 5'd31, 8'h00);
        host_beat(i2cs_pkg::MODE_HRD, 1'b1, 5'd31, 8'hFF);
    endtask

    task automatic test_bus_transaction();
        write_reg(i2cs_pkg::REG_CMD_LEN, 6'd2);
        write_reg(i2cs_pkg::REG_DATA_CAP, 6'd2);
        bus_beat(i2cs_pkg::ST_GC_ARB, 8'h00, 8'h00);
        bus_beat(i2cs_pkg::ST_RX_SLA, 8'hFF, 8'h00);
        bus_beat(i2cs_pkg::ST_RX_GC, 8'h00, 8'h00);
        bus_beat(i2cs_pkg::ST_RX_SLA, 8'h5A, 8'h00);
        bus_beat(i2cs_pkg::ST_RX_SLA, 8'hA5, 8'h00);
        // data limit reached: not-acknowledge
        bus_beat(i2cs_pkg::ST_RX_GC, 8'h3C, 8'h00);
        bus_beat(i2cs_pkg::ST_STOP, 8'h00, 8'hFF);
        bus_beat(i2cs_pkg::ST_TX_SLA, 8'h00, 8'h00);
        bus_beat(i2cs_pkg::ST_TX_ACK, 8'h00, 8'h00);
        bus_beat(i2cs_pkg::ST_TX_ACK, 8'h00, 8'h00);
        bus_beat(i2cs_pkg::ST_TX_NACK, 8'h00, 8'h00);
    endtask

    task automatic test_error_recovery();
        // stop while still in the command phase
        bus_beat(i2cs_pkg::ST_SLA_ARB, 8'h00, 8'h00);
        bus_beat(i2cs_pkg::ST_RX_SLA, 8'h77, 8'h00);
        bus_beat(i2cs_pkg::ST_STOP, 8'h00, 8'h00);
        // read address while a command phase is configured
        bus_beat(i2cs_pkg::ST_TX_ARB, 8'h00, 8'h00);
        bus_beat(ST_BOGUS, 8'h00, 8'h00);
        bus_beat(i2cs_pkg::ST_SLA, 8'h00, 8'h00);
        bus_beat(i2cs_pkg::ST_SLA, 8'h00, 8'h00);
        write_reg(i2cs_pkg::REG_CMD_LEN, 6'd0);
        write_reg(i2cs_pkg::REG_DATA_CAP, 6'd0);
        // read with no command phase, empty transmit window
        bus_beat(i2cs_pkg::ST_TX_ARB, 8'h00, 8'h00);
        bus_beat(i2cs_pkg::ST_TX_NACK, 8'h00, 8'h00);
        bus_beat(i2cs_pkg::ST_SLA, 8'h00, 8'h00);
        bus_beat(i2cs_pkg::ST_RX_GC, 8'h12, 8'h00);
        bus_beat(i2cs_pkg::ST_STOP, 8'h00, 8'h01);
    endtask

    task automatic test_config_sweep();
        int cmd_set [6];
        int cap_set [6];
        int k;
        cmd_set = '{8, 1, 3, 8, 0, 5};
        cap_set = '{32, 5, 0, 1, 17, 32};
        for (k = 0; k < 6; k++)
        begin
            write_reg(i2cs_pkg::REG_CMD_LEN, 6'(cmd_set[k]));
            write_reg(i2cs_pkg::REG_DATA_CAP, 6'(cap_set[k]));
            test_random_traffic(180);
        end
    endtask

    task automatic test_receiver_hold();
        hold_reqs <= hold_reqs + 1;
        test_random_traffic(60);
    endtask

    task automatic test_sender_pause();
        test_random_traffic(40);
        settle();
        test_random_traffic(40);
    endtask

    task automatic test_quiet_tail();
        idle_en <= 1'b0;
        test_random_traffic(250);
    endtask

    always @(posedge clk)
    begin
        if (hold_served != hold_reqs)
        begin
            hold_served <= hold_reqs;
            rx_wait <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            m_tready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            rx_wait <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_resp.ack_action = m_tdata[1:0];
            got_resp.tx_valid = m_tdata[2];
            got_resp.tx_byte = m_tdata[10:3];
            got_resp.stop_seen = m_tlast;
            got_resp.command_count = m_tdata[14:11];
            got_resp.data_count = m_tdata[20:15];
            got_resp.general_call = m_tdata[21];
            got_resp.protocol_error = m_tdata[22];
            got_resp.read_data = m_tdata[30:23];
            if (pending_resp.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected result beat: %s", resp_text(got_resp));
                fail_count++;
            end
            else
            begin
                want_resp = pending_resp.pop_front();
                if (got_resp.ack_action !== want_resp.ack_action ||
                    got_resp.tx_valid !== want_resp.tx_valid ||
                    got_resp.tx_byte !== want_resp.tx_byte ||
                    got_resp.stop_seen !== want_resp.stop_seen ||
                    got_resp.command_count !== want_resp.command_count ||
                    got_resp.data_count !== want_resp.data_count ||
                    got_resp.general_call !== want_resp.general_call ||
                    got_resp.protocol_error !== want_resp.protocol_error ||
                    got_resp.read_data !== want_resp.read_data)
                begin
                    if (fail_count < 10)
                        $display("mismatch at result %0d\n  exp %s\n  got %s", resp_idx,
                                 resp_text(want_resp), resp_text(got_resp));
                    fail_count++;
                end
                resp_idx++;
            end
        end
    end

    always @(negedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat accepted for %0d cycles", stall_cycles);
            $display("** i2c_slave_command_data_engine: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_en <= 1'b1;
        test_host_access();
        test_bus_transaction();
        test_error_recovery();
        test_config_sweep();
        test_receiver_hold();
        test_sender_pause();
        test_quiet_tail();
        s_tvalid <= 1'b0;
        while (pending_resp.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_resp.size() == 0)
            $display("** i2c_slave_command_data_engine: PASSED **");
        else
            $display("** i2c_slave_command_data_engine: FAILED **");
        $finish;
    end

endmodule
